>>> rtl/core/iefp_pkg.sv
package iefp_pkg;

	localparam int BUFFER_DEPTH_DEF = 40;
	localparam int MAX_PAYLOAD_DEF  = 24;

	localparam logic [7:0] SYNC_BYTE     = 8'h55;
	localparam logic [7:0] FIX_ID_LOW    = 8'h51;
	localparam logic [7:0] FIX_ID_HIGH   = 8'h53;
	localparam logic [7:0] VAR_EULER_ID  = 8'h01;
	localparam logic [7:0] VAR_EULER_LEN = 8'd6;
	localparam int         FIX_SIZE      = 11;
	localparam int         VAR_OVERHEAD  = 5;
	localparam logic [13:0] COUNT_LIMIT  = 14'd9999;

	localparam logic [1:0] CMD_BYTE   = 2'd0;
	localparam logic [1:0] CMD_ZERO   = 2'd1;
	localparam logic [1:0] CMD_ERR    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ERR_KIND_MAX = 3'd4;
	localparam logic [2:0] ERR_CODE_BRK = 3'd5;

	typedef enum logic [1:0] {
		ID_RDATA,
		ID_VAR,
		ID_FRAME
	} id_src_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [2:0] error_kind;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] roll_cdeg;
		logic signed [15:0] pitch_cdeg;
		logic signed [15:0] yaw_rel_cdeg;
		logic               angle_valid;
		logic [15:0]        rx_bytes;
		logic [13:0]        angle_frames;
		logic [13:0]        bad_frames;
		logic [7:0]         last_frame_id;
		logic [2:0]         last_error;
		logic [31:0]        recent_bytes;
	} out_item_t;

	typedef struct packed {
		logic       push;
		logic       yaw_zero;
		logic       line_err;
		logic       off_set;
		logic [1:0] off_val;
		logic       off_inc;
		logic       latch_second;
		logic       latch_id;
		logic       start_sum;
		logic       frame_var;
		logic       sum_step;
		logic       drop1;
		logic       drop_frame;
		logic       bad_inc;
		logic       id_rec;
		id_src_t    id_src;
		logic       conv_en;
		logic [1:0] conv_idx;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_lt2;
		logic cnt_lt4;
		logic cnt_lt_fix;
		logic cnt_lt_var;
		logic byte_sync;
		logic byte_fix_id;
		logic len_big;
		logic at_end;
		logic sum_ok;
		logic euler;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/core/iefp_chan_if.sv
interface iefp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/iefp_dpath.sv
module iefp_dpath #(
	parameter int BUFFER_DEPTH = iefp_pkg::BUFFER_DEPTH_DEF,
	parameter int MAX_PAYLOAD  = iefp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iefp_pkg::dp_cmd_t   cmd,
	output iefp_pkg::dp_sts_t   sts,
	input  iefp_pkg::in_item_t  in_item,
	input  logic                out_ready,
	output logic                out_valid,
	output iefp_pkg::out_item_t out_item
);
	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int AW    = PTR_W + 1;
	localparam int VAR_OVERHEAD_C = iefp_pkg::VAR_OVERHEAD;
	localparam iefp_pkg::id_src_t ID_RDATA_C = iefp_pkg::ID_RDATA;
	localparam iefp_pkg::id_src_t ID_VAR_C   = iefp_pkg::ID_VAR;

	logic [7:0]       mem [BUFFER_DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] off_q;
	logic [PTR_W-1:0] end_q;
	logic [7:0]       sum_q;
	logic [7:0]       second_q;
	logic [7:0]       id_q;
	logic [7:0]       len_q;
	logic             var_q;
	logic [7:0]       eb_q [6];

	logic signed [15:0] roll_q, pitch_q, yaw_raw_q, yaw_zero_q;
	logic [15:0]        byte_cnt_q;
	logic [13:0]        good_q, bad_q;
	logic [7:0]         frame_id_q;
	logic [2:0]         err_q;
	logic [31:0]        hist_q;
	logic               valid_flag_q;

	logic [PTR_W-1:0] off_nxt;
	logic [AW-1:0]    rd_sum, wr_sum, drop_sum, drop_n, inc_sum;
	logic [PTR_W-1:0] rd_addr, wr_addr;
	logic             full;
	logic [8:0]       cnt_w, var_size;
	logic [PTR_W-1:0] cap_base, cap_rel;
	logic signed [15:0] raw;
	logic signed [31:0] prod, prod_adj;
	logic signed [15:0] conv_res;
	logic signed [16:0] diff, rel;
	logic [7:0]         frame_id_src;

	always_comb begin
		off_nxt = cmd.off_set ? PTR_W'(cmd.off_val) : (cmd.off_inc ? off_q + 1'b1 : off_q);
		rd_sum  = AW'(head_q) + AW'(off_nxt);
		rd_addr = (rd_sum >= AW'(BUFFER_DEPTH)) ? PTR_W'(rd_sum - AW'(BUFFER_DEPTH))
			: PTR_W'(rd_sum);
		wr_sum  = AW'(head_q) + AW'(cnt_q);
		wr_addr = (wr_sum >= AW'(BUFFER_DEPTH)) ? PTR_W'(wr_sum - AW'(BUFFER_DEPTH))
			: PTR_W'(wr_sum);
		full    = cnt_q == CNT_W'(BUFFER_DEPTH);
		drop_n  = cmd.drop1 ? AW'(1) : AW'(end_q) + AW'(1);
		drop_sum = AW'(head_q) + drop_n;
		inc_sum  = AW'(head_q) + AW'(1);
		cnt_w    = 9'(cnt_q);
		var_size = 9'(rdata_q) + 9'(VAR_OVERHEAD_C);
		cap_base = var_q ? PTR_W'(4) : PTR_W'(2);
		cap_rel  = off_q - cap_base;
	end

	always_comb begin
		sts.cnt_zero    = cnt_q == '0;
		sts.cnt_lt2     = cnt_w < 9'd2;
		sts.cnt_lt4     = cnt_w < 9'd4;
		sts.cnt_lt_fix  = cnt_w < 9'(iefp_pkg::FIX_SIZE);
		sts.cnt_lt_var  = cnt_w < var_size;
		sts.byte_sync   = rdata_q == iefp_pkg::SYNC_BYTE;
		sts.byte_fix_id = rdata_q >= iefp_pkg::FIX_ID_LOW && rdata_q <= iefp_pkg::FIX_ID_HIGH;
		sts.len_big     = 9'(rdata_q) > 9'(MAX_PAYLOAD);
		sts.at_end      = off_q == end_q;
		sts.sum_ok      = sum_q == rdata_q;
		sts.euler       = var_q ? (id_q == iefp_pkg::VAR_EULER_ID
			&& len_q == iefp_pkg::VAR_EULER_LEN) : (second_q == iefp_pkg::FIX_ID_HIGH);
		sts.out_free    = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= in_item.data_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			off_q  <= '0;
		end else begin
			off_q <= off_nxt;
			if (cmd.push) begin
				if (full) begin
					head_q <= (inc_sum >= AW'(BUFFER_DEPTH)) ? '0 : PTR_W'(inc_sum);
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (cmd.drop1 || cmd.drop_frame) begin
				head_q <= (drop_sum >= AW'(BUFFER_DEPTH))
					? PTR_W'(drop_sum - AW'(BUFFER_DEPTH)) : PTR_W'(drop_sum);
				cnt_q  <= cnt_q - CNT_W'(drop_n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_second) begin
			second_q <= rdata_q;
		end
		if (cmd.latch_id) begin
			id_q <= rdata_q;
		end
		if (cmd.start_sum) begin
			sum_q <= '0;
			var_q <= cmd.frame_var;
			len_q <= rdata_q;
			end_q <= cmd.frame_var ? PTR_W'(var_size - 9'd1)
				: PTR_W'(iefp_pkg::FIX_SIZE - 1);
		end
		if (cmd.sum_step) begin
			sum_q <= sum_q + rdata_q;
			if (off_q >= cap_base && cap_rel < PTR_W'(6)) begin
				eb_q[cap_rel[2:0]] <= rdata_q;
			end
		end
	end

	always_comb begin
		case (cmd.conv_idx)
			2'd0:    raw = {eb_q[1], eb_q[0]};
			2'd1:    raw = {eb_q[3], eb_q[2]};
			default: raw = {eb_q[5], eb_q[4]};
		endcase
		prod     = 32'(raw) * 32'sd18000;
		prod_adj = prod[31] ? prod + 32'sd32767 : prod;
		conv_res = 16'(prod_adj >>> 15);
		diff     = 17'(yaw_raw_q) - 17'(yaw_zero_q);
		rel      = diff;
		if (diff > 17'sd18000) begin
			rel = diff - 17'sd36000;
		end else if (diff < -17'sd18000) begin
			rel = diff + 17'sd36000;
		end
		case (cmd.id_src)
			ID_RDATA_C: frame_id_src = rdata_q;
			ID_VAR_C:   frame_id_src = id_q;
			default:    frame_id_src = var_q ? id_q : second_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q       <= '0;
			pitch_q      <= '0;
			yaw_raw_q    <= '0;
			yaw_zero_q   <= '0;
			byte_cnt_q   <= '0;
			good_q       <= '0;
			bad_q        <= '0;
			frame_id_q   <= '0;
			err_q        <= '0;
			hist_q       <= '0;
			valid_flag_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				byte_cnt_q <= byte_cnt_q + 16'd1;
				hist_q     <= {hist_q[23:0], in_item.data_byte};
			end
			if (cmd.yaw_zero) begin
				yaw_zero_q <= yaw_raw_q;
			end
			if (cmd.line_err) begin
				err_q <= (in_item.error_kind > iefp_pkg::ERR_KIND_MAX)
					? iefp_pkg::ERR_CODE_BRK : in_item.error_kind + 3'd1;
			end
			if ((cmd.bad_inc || cmd.line_err || (cmd.push && full))
				&& bad_q < iefp_pkg::COUNT_LIMIT) begin
				bad_q <= bad_q + 14'd1;
			end
			if (cmd.id_rec) begin
				frame_id_q <= frame_id_src;
			end
			if (cmd.conv_en) begin
				case (cmd.conv_idx)
					2'd0: begin
						roll_q       <= conv_res;
						valid_flag_q <= 1'b1;
						if (good_q < iefp_pkg::COUNT_LIMIT) begin
							good_q <= good_q + 14'd1;
						end
					end
					2'd1:    pitch_q   <= conv_res;
					default: yaw_raw_q <= conv_res;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_item.roll_cdeg     <= roll_q;
			out_item.pitch_cdeg    <= pitch_q;
			out_item.yaw_rel_cdeg  <= 16'(rel);
			out_item.angle_valid   <= valid_flag_q;
			out_item.rx_bytes      <= byte_cnt_q;
			out_item.angle_frames  <= good_q;
			out_item.bad_frames    <= bad_q;
			out_item.last_frame_id <= frame_id_q;
			out_item.last_error    <= err_q;
			out_item.recent_bytes  <= hist_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_DEPTH))
		else $error("pending count above buffer depth");
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && full |=> cnt_q == CNT_W'(BUFFER_DEPTH))
		else $error("push at full buffer lost occupancy");
	a_drop_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop_frame |-> AW'(cnt_q) >= drop_n)
		else $error("frame drop beyond pending bytes");
	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		good_q <= iefp_pkg::COUNT_LIMIT && bad_q <= iefp_pkg::COUNT_LIMIT)
		else $error("frame counter above limit");
`endif

endmodule

>>> rtl/core/iefp_ctrl.sv
module iefp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_cmd,
	output logic              in_ready,
	input  iefp_pkg::dp_sts_t sts,
	output iefp_pkg::dp_cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_SUM,
		ST_CONV,
		ST_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] conv_q;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.id_src = iefp_pkg::ID_RDATA;
		cmd.conv_idx = conv_q;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DONE;
					case (in_cmd)
						iefp_pkg::CMD_BYTE: begin
							cmd.push = 1'b1;
							state_d  = ST_SCAN;
						end
						iefp_pkg::CMD_ZERO: cmd.yaw_zero = 1'b1;
						iefp_pkg::CMD_ERR:  cmd.line_err = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.cnt_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.off_set = 1'b1;
					cmd.off_val = 2'd0;
					state_d     = ST_B0;
				end
			end
			ST_B0: begin
				if (!sts.byte_sync) begin
					cmd.drop1 = 1'b1;
					state_d   = ST_SCAN;
				end else if (sts.cnt_lt2) begin
					state_d = ST_DONE;
				end else begin
					cmd.off_set = 1'b1;
					cmd.off_val = 2'd1;
					state_d     = ST_B1;
				end
			end
			ST_B1: begin
				cmd.latch_second = 1'b1;
				if (sts.byte_sync) begin
					if (sts.cnt_lt4) begin
						state_d = ST_DONE;
					end else begin
						cmd.off_set = 1'b1;
						cmd.off_val = 2'd2;
						state_d     = ST_B2;
					end
				end else if (!sts.byte_fix_id) begin
					cmd.id_rec  = 1'b1;
					cmd.bad_inc = 1'b1;
					cmd.drop1   = 1'b1;
					state_d     = ST_SCAN;
				end else if (sts.cnt_lt_fix) begin
					state_d = ST_DONE;
				end else begin
					cmd.start_sum = 1'b1;
					cmd.off_set   = 1'b1;
					cmd.off_val   = 2'd0;
					state_d       = ST_SUM;
				end
			end
			ST_B2: begin
				cmd.latch_id = 1'b1;
				cmd.off_set  = 1'b1;
				cmd.off_val  = 2'd3;
				state_d      = ST_B3;
			end
			ST_B3: begin
				if (sts.len_big) begin
					cmd.id_rec  = 1'b1;
					cmd.id_src  = iefp_pkg::ID_VAR;
					cmd.bad_inc = 1'b1;
					cmd.drop1   = 1'b1;
					state_d     = ST_SCAN;
				end else if (sts.cnt_lt_var) begin
					state_d = ST_DONE;
				end else begin
					cmd.start_sum = 1'b1;
					cmd.frame_var = 1'b1;
					cmd.off_set   = 1'b1;
					cmd.off_val   = 2'd0;
					state_d       = ST_SUM;
				end
			end
			ST_SUM: begin
				if (sts.at_end) begin
					cmd.id_rec     = 1'b1;
					cmd.id_src     = iefp_pkg::ID_FRAME;
					cmd.bad_inc    = !sts.sum_ok;
					cmd.drop_frame = 1'b1;
					state_d        = (sts.sum_ok && sts.euler) ? ST_CONV : ST_SCAN;
				end else begin
					cmd.sum_step = 1'b1;
					cmd.off_inc  = 1'b1;
				end
			end
			ST_CONV: begin
				cmd.conv_en = 1'b1;
				if (conv_q == 2'd2) begin
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conv_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV) begin
				conv_q <= (conv_q == 2'd2) ? 2'd0 : conv_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_conv_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV && conv_q == 2'd2 |=> state_q == ST_SCAN && conv_q == 2'd0)
		else $error("decode sequence did not finish");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted item produced no status");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == ST_IDLE)
		else $error("status loaded outside completion");
`endif

endmodule

>>> rtl/core/imu_euler_frame_parser_core.sv
// Parses IMU link bytes into roll, pitch and relative yaw in centidegrees, and returns one
// status item for every accepted input item. Bytes land in a circular buffer of
// BUFFER_DEPTH entries that is rescanned after every byte for fixed 11-byte frames and
// variable 0x55 0x55 frames; the buffer has one read port, so the scan reads one byte per
// cycle. A byte item is pushed into the buffer, then the scan drops bytes from the head,
// checks headers, sums each complete frame (up to MAX_PAYLOAD + 5 bytes) and decodes
// roll, pitch and yaw from each Euler frame that passes its checksum. A finished status
// item waits in an output register, and the next input item is taken while it waits.
module imu_euler_frame_parser_core #(
	parameter int BUFFER_DEPTH = iefp_pkg::BUFFER_DEPTH_DEF,
	parameter int MAX_PAYLOAD  = iefp_pkg::MAX_PAYLOAD_DEF
) (
	input logic         clk,
	input logic         arst_n,
	iefp_chan_if.sink   link,
	iefp_chan_if.source status
);
	iefp_pkg::dp_cmd_t cmd;
	iefp_pkg::dp_sts_t sts;

	iefp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link.valid),
		.in_cmd   (link.payload.cmd),
		.in_ready (link.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iefp_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_PAYLOAD  (MAX_PAYLOAD)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (link.payload),
		.out_ready (status.ready),
		.out_valid (status.valid),
		.out_item  (status.payload)
	);

endmodule
